>>> src/bwod_pkg.sv
package bwod_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int NUM_W         = 23;
  localparam logic [NUM_W-1:0] COUNT_MAX = 23'h7FFFFF;
  localparam int CFG_DATA_W    = 13;

  localparam logic [1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [7:0]  THRESHOLD_RST = 8'd240;
  localparam logic [10:0] WIDTH_RST     = 11'd640;
  localparam logic [12:0] HEIGHT_RST    = 13'd480;

  localparam logic KIND_3X3 = 1'b0;
  localparam logic KIND_5X5 = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [9:0]       centre_x;
    logic [11:0]      centre_y;
    logic [24:0]      bits;
    logic [NUM_W-1:0] number;
    logic             last;
  } res_t;

  function automatic logic [NUM_W-1:0] sat_inc(input logic [NUM_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + NUM_W'(1);
  endfunction

endpackage

>>> src/bwod_line_mem.sv
module bwod_line_mem
  import bwod_pkg::*;
#(
  parameter int DEPTH = MAX_WIDTH_DEF,
  parameter int AW    = $clog2(MAX_WIDTH_DEF)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [3:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [3:0]    wr_data
);

  logic [3:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/bwod_window_eval.sv
module bwod_window_eval
  import bwod_pkg::*;
#(
  parameter int XW = $clog2(MAX_WIDTH_DEF)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [4:0]    col,
  input  logic [XW-1:0] x,
  input  logic [11:0]   y,
  input  logic          first,
  output res_t          res_a,
  output res_t          res_b,
  output logic [1:0]    res_n
);

  localparam int XE = (XW > 10) ? XW : 10;

  logic [24:0]      window_reg;
  logic [24:0]      window_next;
  logic [NUM_W-1:0] window_counter;
  logic [NUM_W-1:0] counter_next;
  logic [8:0]       bits3;
  logic [24:0]      bits5;
  logic             has3;
  logic             has5;
  logic [XE-1:0]    xe;
  logic [NUM_W-1:0] base;
  logic [NUM_W-1:0] num_a;
  logic [NUM_W-1:0] num_b;
  res_t             r3;
  res_t             r5;

  assign window_next = {window_reg[19:0], col};

  // column age c, row age k -> output bit (size-1-c)*size + (size-1-k)
  always_comb begin
    bits3 = '0;
    bits5 = '0;
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        bits3[(2-c)*3 + (2-k)] = window_next[5*c + k];
      end
    end
    for (int c = 0; c < 5; c++) begin
      for (int k = 0; k < 5; k++) begin
        bits5[(4-c)*5 + (4-k)] = window_next[5*c + k];
      end
    end
  end

  assign xe   = XE'(x);
  assign has3 = (x >= XW'(2)) && (y >= 12'd2) && (bits3 != '0);
  assign has5 = (x >= XW'(4)) && (y >= 12'd4) && (bits5 != '0);

  assign base  = first ? '0 : window_counter;
  assign num_a = sat_inc(base);
  assign num_b = sat_inc(num_a);

  always_comb begin
    r3.kind     = KIND_3X3;
    r3.centre_x = 10'(xe - XE'(1));
    r3.centre_y = y - 12'd1;
    r3.bits     = {16'd0, bits3};
    r3.number   = num_a;
    r3.last     = ~has5;
    r5.kind     = KIND_5X5;
    r5.centre_x = 10'(xe - XE'(2));
    r5.centre_y = y - 12'd2;
    r5.bits     = bits5;
    r5.number   = has3 ? num_b : num_a;
    r5.last     = 1'b1;
  end

  assign res_a = has3 ? r3 : r5;
  assign res_b = r5;
  assign res_n = 2'(has3) + 2'(has5);

  always_comb begin
    case (res_n)
      2'd0:    counter_next = base;
      2'd1:    counter_next = num_a;
      default: counter_next = num_b;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_reg     <= '0;
      window_counter <= '0;
    end else if (go) begin
      window_reg     <= window_next;
      window_counter <= counter_next;
    end
  end

endmodule

>>> src/bwod_result_queue.sv
module bwod_result_queue
  import bwod_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  res_t       push_a,
  input  res_t       push_b,
  input  logic       pop,
  output res_t       head,
  output logic [1:0] count
);

  res_t       q [2];
  res_t       q_next [2];
  logic [1:0] count_next;
  logic [1:0] left;

  assign head = q[0];
  assign left = count - 2'(pop);

  always_comb begin
    q_next[0] = pop ? q[1] : q[0];
    q_next[1] = q[1];
    case (left)
      2'd0: begin
        if (push_n != 2'd0) q_next[0] = push_a;
        if (push_n == 2'd2) q_next[1] = push_b;
      end
      2'd1: begin
        if (push_n != 2'd0) q_next[1] = push_a;
      end
      default: ;
    endcase
    count_next = left + push_n;
  end

  always_ff @(posedge clk) begin
    q[0] <= q_next[0];
    q[1] <= q_next[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

>>> src/binary_window_occupancy_detector_core.sv
// channel  dir  signals                          contents
// s_       in   s_tvalid s_tready s_tdata[23:0]  pixel request: red, green, blue
// m_       out  m_tvalid m_tready m_tdata[71:0]  window result, m_tlast, m_tuser kind
// cfg_     in   cfg_valid cfg_ready              register write, cfg_index, cfg_data
//
// one pixel per cycle while the queue has room; results leave one per cycle while m_tready is high,
// so a pixel with two results holds the input until the queue has room for both
// a taken pixel is registered into s1 with its line store read, then evaluated and pushed into the queue
// after reset a clear pass over all MAX_WIDTH addresses zeroes the line store; s_tready stays low
// cfg_ready is always high; a stalled m_ side backs up into s_tready through a 2-deep queue
module binary_window_occupancy_detector_core
  import bwod_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,   // red, green, blue
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [71:0]           m_tdata,   // centre_x, centre_y, window_bits, window_number
  output logic                  m_tlast,   // last_in_run
  output logic                  m_tuser,   // window_kind
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int EW = (XW + 1 > 11) ? XW + 1 : 11;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t          state;
  logic [XW-1:0]   clr_addr;

  logic [7:0]      threshold;
  logic [10:0]     frame_width;
  logic [12:0]     frame_height;
  logic [EW-1:0]   eff_width;
  logic [12:0]     eff_height;

  logic [XW-1:0]   column_count;
  logic [11:0]     row_count;

  logic            s1_valid;
  logic [XW-1:0]   s1_x;
  logic [11:0]     s1_y;
  logic            s1_drawn;
  logic            s1_first;
  logic            s1_fwd;
  logic [3:0]      s1_fwd_data;
  logic            s1_go;

  logic            accept;
  logic            drawn;
  logic [3:0]      rd_data;
  logic [3:0]      line_bits;
  logic [4:0]      col;
  logic            wr_en;
  logic [XW-1:0]   wr_addr;
  logic [3:0]      wr_data;

  res_t            res_a;
  res_t            res_b;
  logic [1:0]      res_n;
  res_t            head;
  logic [1:0]      q_count;
  logic            pop;
  logic [2:0]      fill;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RST;
      frame_width  <= WIDTH_RST;
      frame_height <= HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD:    threshold    <= cfg_data[7:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width == 11'd0) begin
      eff_width = EW'(1);
    end else if (EW'(frame_width) > EW'(MAX_WIDTH)) begin
      eff_width = EW'(MAX_WIDTH);
    end else begin
      eff_width = EW'(frame_width);
    end
    if (frame_height == 13'd0) begin
      eff_height = 13'd1;
    end else if (frame_height > 13'(MAX_HEIGHT)) begin
      eff_height = 13'(MAX_HEIGHT);
    end else begin
      eff_height = frame_height;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + XW'(1);
          if (clr_addr == XW'(MAX_WIDTH - 1)) state <= ST_RUN;
        end
        ST_RUN: ;
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // room check: what remains after this cycle's pop plus this pixel's results
  assign pop      = m_tvalid && m_tready;
  assign fill     = 3'(q_count) - 3'(pop) + 3'(res_n);
  assign s1_go    = s1_valid && (fill <= 3'd2);
  assign s_tready = (state == ST_RUN) && (!s1_valid || s1_go);
  assign accept   = s_tvalid && s_tready;

  assign drawn = (s_tdata[7:0] < threshold) || (s_tdata[15:8] < threshold) ||
                 (s_tdata[23:16] < threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (EW'(column_count) + EW'(1) >= eff_width) begin
        column_count <= '0;
        if (13'(row_count) + 13'd1 >= eff_height) row_count <= '0;
        else row_count <= row_count + 12'd1;
      end else begin
        column_count <= column_count + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // the write of the leaving pixel lands on the same edge as this read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x        <= column_count;
      s1_y        <= row_count;
      s1_drawn    <= drawn;
      s1_first    <= (column_count == '0) && (row_count == 12'd0);
      s1_fwd      <= s1_go && (s1_x == column_count);
      s1_fwd_data <= col[3:0];
    end
  end

  assign line_bits = s1_fwd ? s1_fwd_data : rd_data;
  assign col       = {line_bits, s1_drawn};

  assign wr_en   = (state == ST_CLEAR) || s1_go;
  assign wr_addr = (state == ST_CLEAR) ? clr_addr : s1_x;
  assign wr_data = (state == ST_CLEAR) ? 4'd0 : col[3:0];

  bwod_line_mem #(
    .DEPTH(MAX_WIDTH),
    .AW   (XW)
  ) u_line_mem (
    .clk    (clk),
    .rd_en  (accept),
    .rd_addr(column_count),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  bwod_window_eval #(
    .XW(XW)
  ) u_window_eval (
    .clk  (clk),
    .rst  (rst),
    .go   (s1_go),
    .col  (col),
    .x    (s1_x),
    .y    (s1_y),
    .first(s1_first),
    .res_a(res_a),
    .res_b(res_b),
    .res_n(res_n)
  );

  bwod_result_queue u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push_n(s1_go ? res_n : 2'd0),
    .push_a(res_a),
    .push_b(res_b),
    .pop   (pop),
    .head  (head),
    .count (q_count)
  );

  assign m_tvalid = (q_count != 2'd0);
  assign m_tdata  = {2'b00, head.number, head.bits, head.centre_y, head.centre_x};
  assign m_tlast  = head.last;
  assign m_tuser  = head.kind;

endmodule
